// File: src/vefe_pkg.sv
// ----------------------------------------------------------------------------
// vefe_pkg
// shared types, constants and helper functions of the voxel face extractor
// ----------------------------------------------------------------------------
package vefe_pkg;

  localparam int MAX_X  = 32;
  localparam int MAX_Y  = 32;
  localparam int MAX_Z  = 32;
  localparam int POS_W  = 5;
  localparam int CFG_W  = 6;
  localparam int VAL_W  = 8;
  localparam int COL_W  = 8;
  localparam int DIR_W  = 3;
  localparam int NB_N   = 6;
  localparam int CIDX_W = 3;
  localparam int ADDR_W = $clog2(MAX_X * MAX_Y * MAX_Z);
  localparam int CRD_W  = POS_W + 2;

  localparam logic [CIDX_W-1:0] CFG_SIZE_X      = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_SIZE_Y      = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_SIZE_Z      = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_SLICE_LIMIT = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_SHADER_MODE = 3'd4;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [DIR_W-1:0] DIR_NX = 3'd0;
  localparam logic [DIR_W-1:0] DIR_PX = 3'd1;
  localparam logic [DIR_W-1:0] DIR_NY = 3'd2;
  localparam logic [DIR_W-1:0] DIR_PY = 3'd3;
  localparam logic [DIR_W-1:0] DIR_PZ = 3'd4;
  localparam logic [DIR_W-1:0] DIR_NZ = 3'd5;

  localparam logic [COL_W-1:0] COL_FULL = 8'd240;
  localparam logic [COL_W-1:0] COL_NONE = 8'd0;

  localparam logic [CFG_W-1:0] SIZE_RST  = 6'd32;
  localparam logic [CFG_W-1:0] SLICE_RST = 6'd32;

  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic signed [CRD_W-1:0] crd_t;
  typedef logic [CFG_W-1:0]        cfg_t;

  // centre first, then -x,+x,-y,+y,+z,-z, last entry unused
  localparam logic signed [1:0] NB_DX [8] =
    '{2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd0};
  localparam logic signed [1:0] NB_DY [8] =
    '{2'sd0, 2'sd0, 2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd0, 2'sd0};
  localparam logic signed [1:0] NB_DZ [8] =
    '{2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd0};

  typedef struct packed {
    logic             cmd;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic [VAL_W-1:0] value;
  } vefe_in_t;

  typedef struct packed {
    logic             face_valid;
    logic [DIR_W-1:0] face_dir;
    logic [POS_W-1:0] out_x;
    logic [POS_W-1:0] out_y;
    logic [POS_W-1:0] out_z;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
    logic             last;
  } vefe_out_t;

  typedef struct packed {
    logic             en;
    addr_t            addr;
    logic [VAL_W-1:0] data;
  } vefe_wr_t;

  typedef struct packed {
    logic [COL_W-1:0] r;
    logic [COL_W-1:0] g;
    logic [COL_W-1:0] b;
  } rgb_t;

  function automatic cfg_t eff_size(cfg_t s, int cap);
    return (s > cfg_t'(cap)) ? cfg_t'(cap) : s;
  endfunction

  function automatic logic crd_ok(crd_t c, cfg_t lim);
    return (c >= 0) && (cfg_t'(c) < lim);
  endfunction

  function automatic addr_t addr_of(crd_t x, crd_t y, crd_t z);
    return addr_t'(z) * addr_t'(MAX_X * MAX_Y) + addr_t'(y) * addr_t'(MAX_X) + addr_t'(x);
  endfunction

  function automatic rgb_t shade(logic odd, logic [DIR_W-1:0] dir, logic zodd, logic mode);
    rgb_t c;
    logic ax_x;
    logic ax_y;
    logic ax_z;
    ax_x = (dir == DIR_NX) || (dir == DIR_PX);
    ax_y = (dir == DIR_NY) || (dir == DIR_PY);
    ax_z = (dir == DIR_PZ) || (dir == DIR_NZ);
    c.r  = odd ? COL_FULL : COL_NONE;
    c.g  = COL_FULL;
    c.b  = odd ? COL_FULL : COL_NONE;
    if (!mode) begin
      c.r = c.r >> ax_x;
      c.g = c.g >> ax_y;
      c.b = c.b >> ax_z;
      c.r = c.r >> zodd;
      c.g = c.g >> zodd;
      c.b = c.b >> zodd;
    end else if (ax_x) begin
      c.r = c.r >> 1;
      c.g = c.g >> 1;
      c.b = c.b >> 1;
    end else if (ax_y) begin
      c.r = c.r >> 2;
      c.g = c.g >> 2;
      c.b = c.b >> 2;
    end
    return c;
  endfunction

endpackage

// File: src/vefe_if.sv
// ----------------------------------------------------------------------------
// vefe_if
// request and result channels of the voxel face extractor
// ----------------------------------------------------------------------------
interface vefe_in_if import vefe_pkg::*; ();
  logic     valid;
  logic     ready;
  vefe_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vefe_out_if import vefe_pkg::*; ();
  logic      valid;
  logic      ready;
  vefe_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/voxel_exposed_face_extract_top.sv
// ----------------------------------------------------------------------------
// voxel_exposed_face_extract_top
// Six-neighbour exposed-face extractor over a 32x32x32 byte volume. After
// reset the volume is swept to zero, during which no request is taken
// (configuration writes are). A write request leaves the block ready for the
// next request. A query reads the voxel and its six neighbours one at a time
// through the single read port of the store, then delivers one result per
// cycle while the output is taken, 1 to 6 results in all. The next request is
// taken as soon as the last result of a query sits in the output register.
// ----------------------------------------------------------------------------
module voxel_exposed_face_extract_top import vefe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  vefe_in_if.sink           in_req,
  vefe_out_if.source        out_resp,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_EMIT} state_t;

  state_t           state_r;
  cfg_t             size_x_r;
  cfg_t             size_y_r;
  cfg_t             size_z_r;
  cfg_t             slice_r;
  logic             mode_r;
  logic [POS_W-1:0] q_x_r;
  logic [POS_W-1:0] q_y_r;
  logic [POS_W-1:0] q_z_r;
  logic [2:0]       cnt_r;
  logic             pend_r;
  logic [2:0]       pidx_r;
  logic             pinr_r;
  logic             centre_nz_r;
  logic             centre_odd_r;
  logic [NB_N-1:0]  empty_r;
  logic             out_valid_r;
  vefe_out_t        out_data_r;

  cfg_t             eff_x;
  cfg_t             eff_y;
  cfg_t             eff_z;
  logic             in_fire;
  logic             load;
  crd_t             wx;
  crd_t             wy;
  crd_t             wz;
  crd_t             nx;
  crd_t             ny;
  crd_t             nz;
  logic             n_ok;
  vefe_wr_t         wr;
  addr_t            rd_addr;
  logic [VAL_W-1:0] rd_data;
  logic             busy;
  logic [DIR_W-1:0] pick;
  logic [NB_N-1:0]  rem;
  rgb_t             col;

  vefe_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .busy    (busy)
  );

  assign eff_x = eff_size(size_x_r, MAX_X);
  assign eff_y = eff_size(size_y_r, MAX_Y);
  assign eff_z = eff_size(size_z_r, MAX_Z);

  assign in_req.ready   = (state_r == ST_IDLE);
  assign in_fire        = in_req.valid && in_req.ready;
  assign load           = (state_r == ST_EMIT) && (!out_valid_r || out_resp.ready);
  assign out_resp.valid = out_valid_r;
  assign out_resp.data  = out_data_r;

  // write path
  assign wx      = crd_t'(in_req.data.pos_x);
  assign wy      = crd_t'(in_req.data.pos_y);
  assign wz      = crd_t'(in_req.data.pos_z);
  assign wr.en   = in_fire && (in_req.data.cmd == CMD_WRITE) && crd_ok(wx, eff_x)
                   && crd_ok(wy, eff_y) && crd_ok(wz, eff_z) && crd_ok(wz, slice_r);
  assign wr.addr = addr_of(wx, wy, wz);
  assign wr.data = in_req.data.value;

  // neighbour read path
  assign nx      = crd_t'(q_x_r) + crd_t'(NB_DX[cnt_r]);
  assign ny      = crd_t'(q_y_r) + crd_t'(NB_DY[cnt_r]);
  assign nz      = crd_t'(q_z_r) + crd_t'(NB_DZ[cnt_r]);
  assign n_ok    = crd_ok(nx, eff_x) && crd_ok(ny, eff_y) && crd_ok(nz, eff_z)
                   && crd_ok(nz, slice_r);
  assign rd_addr = addr_of(nx, ny, nz);

  always_comb begin
    pick = DIR_NX;
    for (int i = NB_N - 1; i >= 0; i--) begin
      if (empty_r[i]) begin
        pick = DIR_W'(i);
      end
    end
    rem       = empty_r;
    rem[pick] = 1'b0;
    col       = shade(centre_odd_r, pick, q_z_r[0], mode_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_RST;
      size_y_r <= SIZE_RST;
      size_z_r <= SIZE_RST;
      slice_r  <= SLICE_RST;
      mode_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SIZE_X:      size_x_r <= cfg_wdata;
        CFG_SIZE_Y:      size_y_r <= cfg_wdata;
        CFG_SIZE_Z:      size_z_r <= cfg_wdata;
        CFG_SLICE_LIMIT: slice_r  <= cfg_wdata;
        CFG_SHADER_MODE: mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (out_resp.ready) begin
        out_valid_r <= 1'b0;
      end
      pend_r <= (state_r == ST_READ) && (cnt_r != 3'd7);
      pidx_r <= cnt_r;
      pinr_r <= n_ok;
      if (pend_r) begin
        if (pidx_r == 3'd0) begin
          centre_nz_r  <= pinr_r && (rd_data != '0);
          centre_odd_r <= rd_data[0];
        end else begin
          empty_r[3'(pidx_r - 3'd1)] <= !(pinr_r && (rd_data != '0));
        end
      end
      case (state_r)
        ST_CLEAR: begin
          if (!busy) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire && (in_req.data.cmd == CMD_QUERY)) begin
            q_x_r   <= in_req.data.pos_x;
            q_y_r   <= in_req.data.pos_y;
            q_z_r   <= in_req.data.pos_z;
            cnt_r   <= '0;
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load) begin
            out_valid_r      <= 1'b1;
            out_data_r.out_x <= q_x_r;
            out_data_r.out_y <= q_y_r;
            out_data_r.out_z <= q_z_r;
            if (centre_nz_r && (empty_r != '0)) begin
              out_data_r.face_valid <= 1'b1;
              out_data_r.face_dir   <= pick;
              out_data_r.red        <= col.r;
              out_data_r.green      <= col.g;
              out_data_r.blue       <= col.b;
              out_data_r.last       <= (rem == '0);
              empty_r               <= rem;
              if (rem == '0) begin
                state_r <= ST_IDLE;
              end
            end else begin
              out_data_r.face_valid <= 1'b0;
              out_data_r.face_dir   <= DIR_NX;
              out_data_r.red        <= COL_NONE;
              out_data_r.green      <= COL_NONE;
              out_data_r.blue       <= COL_NONE;
              out_data_r.last       <= 1'b1;
              state_r               <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: src/vefe_store.sv
// ----------------------------------------------------------------------------
// vefe_store
// byte-per-voxel store, one write and one registered read port, swept to zero
// after reset
// ----------------------------------------------------------------------------
module vefe_store import vefe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  vefe_wr_t         wr,
  input  addr_t            rd_addr,
  output logic [VAL_W-1:0] rd_data,
  output logic             busy
);

  logic [VAL_W-1:0] mem [MAX_X * MAX_Y * MAX_Z];
  logic [VAL_W-1:0] rd_data_r;
  logic [ADDR_W:0]  clr_cnt_r;
  logic [ADDR_W:0]  clr_cnt_nxt;
  logic             we;
  addr_t            wa;
  logic [VAL_W-1:0] wd;

  assign busy        = !clr_cnt_r[ADDR_W];
  assign clr_cnt_nxt = clr_cnt_r + 1'b1;
  assign we          = busy || wr.en;
  assign wa          = busy ? clr_cnt_r[ADDR_W-1:0] : wr.addr;
  assign wd          = busy ? '0 : wr.data;
  assign rd_data     = rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (busy) begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

// File: src/vefe_checker.sv
// ----------------------------------------------------------------------------
// vefe_checker
// port-level checks of the voxel face extractor, bound to the top level
// ----------------------------------------------------------------------------
module vefe_checker import vefe_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_cmd,
  input logic             out_valid,
  input logic             out_ready,
  input logic             face_valid,
  input logic [DIR_W-1:0] face_dir,
  input logic [COL_W-1:0] red,
  input logic [COL_W-1:0] green,
  input logic [COL_W-1:0] blue,
  input logic             last
);

  logic             q_fire;
  logic             o_fire;
  logic [1:0]       open_r;
  logic             mid_r;
  logic [DIR_W-1:0] prev_dir_r;

  assign q_fire = in_valid && in_ready && (in_cmd == CMD_QUERY);
  assign o_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
      mid_r  <= 1'b0;
    end else begin
      open_r <= open_r + {1'b0, q_fire} - {1'b0, o_fire && last};
      if (o_fire) begin
        mid_r      <= !last;
        prev_dir_r <= face_dir;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  a_out_owned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> open_r != 2'd0)
    else $error("result without an open query");

  a_no_face: assert property (@(posedge clk) disable iff (!rst_n)
    o_fire && !face_valid |-> last && red == '0 && green == '0 && blue == '0
      && face_dir == DIR_NX)
    else $error("malformed no-face result");

  a_dir_order: assert property (@(posedge clk) disable iff (!rst_n)
    o_fire && mid_r |-> face_valid && face_dir > prev_dir_r)
    else $error("faces of one query out of order");

endmodule

bind voxel_exposed_face_extract_top vefe_checker u_vefe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .in_cmd     (in_req.data.cmd),
  .out_valid  (out_resp.valid),
  .out_ready  (out_resp.ready),
  .face_valid (out_resp.data.face_valid),
  .face_dir   (out_resp.data.face_dir),
  .red        (out_resp.data.red),
  .green      (out_resp.data.green),
  .blue       (out_resp.data.blue),
  .last       (out_resp.data.last)
);

// File: tb/voxel_face_checker.sv
// ----------------------------------------------------------------------------
// voxel_face_checker
// watches the request, result and register ports of the face extractor, keeps
// its own copy of the volume and registers, works out the faces of every
// accepted query and compares each result field by field in arrival order
// ----------------------------------------------------------------------------
module voxel_face_checker import vefe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  vefe_in_if                in_mon,
  vefe_out_if               out_mon,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output int                pending,
  output int                mismatch_cnt,
  output int                result_cnt,
  output int                face_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VOL_N = MAX_X * MAX_Y * MAX_Z;
  localparam int STEP_X [NB_N] = '{-1, 1, 0, 0, 0, 0};
  localparam int STEP_Y [NB_N] = '{0, 0, -1, 1, 0, 0};
  localparam int STEP_Z [NB_N] = '{0, 0, 0, 0, 1, -1};
  localparam logic [DIR_W-1:0] FACE_DIR [NB_N] =
    '{DIR_NX, DIR_PX, DIR_NY, DIR_PY, DIR_PZ, DIR_NZ};

  logic [VAL_W-1:0] volume [VOL_N];
  cfg_t             lim_x;
  cfg_t             lim_y;
  cfg_t             lim_z;
  cfg_t             lim_slice;
  logic             shade_grey;
  vefe_out_t        faces_due [$];

  function automatic int clamp_extent(cfg_t s, int cap);
    return (int'(s) < cap) ? int'(s) : cap;
  endfunction

  function automatic bit voxel_live(int x, int y, int z);
    return x >= 0 && y >= 0 && z >= 0 &&
           x < clamp_extent(lim_x, MAX_X) && y < clamp_extent(lim_y, MAX_Y) &&
           z < clamp_extent(lim_z, MAX_Z) && z < int'(lim_slice);
  endfunction

  function automatic int vox_addr(int x, int y, int z);
    return (z * MAX_Y + y) * MAX_X + x;
  endfunction

  function automatic logic [VAL_W-1:0] voxel_at(int x, int y, int z);
    if (!voxel_live(x, y, z)) return '0;
    return volume[vox_addr(x, y, z)];
  endfunction

  task automatic predict_faces(vefe_in_t req);
    int               x;
    int               y;
    int               z;
    int               d;
    int               n;
    int               r0;
    int               b0;
    int               r;
    int               g;
    int               b;
    logic [VAL_W-1:0] centre;
    vefe_out_t        f;
    x      = req.pos_x;
    y      = req.pos_y;
    z      = req.pos_z;
    n      = 0;
    centre = voxel_at(x, y, z);
    r0     = centre[0] ? int'(COL_FULL) : int'(COL_NONE);
    b0     = r0;
    f      = '0;
    f.out_x = req.pos_x;
    f.out_y = req.pos_y;
    f.out_z = req.pos_z;
    if (centre != '0) begin
      for (d = 0; d < NB_N; d++) begin
        if (voxel_at(x + STEP_X[d], y + STEP_Y[d], z + STEP_Z[d]) == '0) begin
          r = r0;
          g = COL_FULL;
          b = b0;
          if (!shade_grey) begin
            if (d / 2 == 0) r = r / 2;
            if (d / 2 == 1) g = g / 2;
            if (d / 2 == 2) b = b / 2;
            if (z % 2 != 0) begin
              r = r / 2;
              g = g / 2;
              b = b / 2;
            end
          end else if (d / 2 == 0) begin
            r = r / 2;
            g = g / 2;
            b = b / 2;
          end else if (d / 2 == 1) begin
            r = r / 4;
            g = g / 4;
            b = b / 4;
          end
          f.face_valid = 1'b1;
          f.face_dir   = FACE_DIR[d];
          f.red        = COL_W'(r);
          f.green      = COL_W'(g);
          f.blue       = COL_W'(b);
          f.last       = 1'b0;
          faces_due.push_back(f);
          n++;
        end
      end
    end
    if (n == 0) begin
      f.face_valid = 1'b0;
      f.face_dir   = DIR_NX;
      f.red        = COL_NONE;
      f.green      = COL_NONE;
      f.blue       = COL_NONE;
      f.last       = 1'b1;
      faces_due.push_back(f);
    end else begin
      faces_due[faces_due.size() - 1].last = 1'b1;
    end
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin
    vefe_out_t want;
    vefe_out_t got;
    if (!rst_n) begin
      foreach (volume[i]) volume[i] = '0;
      lim_x        = SIZE_RST;
      lim_y        = SIZE_RST;
      lim_z        = SIZE_RST;
      lim_slice    = SLICE_RST;
      shade_grey   = 1'b0;
      mismatch_cnt = 0;
      result_cnt   = 0;
      face_cnt     = 0;
      faces_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        result_cnt++;
        if (faces_due.size() == 0) begin
          $error("result with nothing outstanding: %p", got);
          mismatch_cnt++;
        end else begin
          want = faces_due.pop_front();
          check_field("face_valid", want.face_valid, got.face_valid);
          check_field("face_dir", want.face_dir, got.face_dir);
          check_field("out_x", want.out_x, got.out_x);
          check_field("out_y", want.out_y, got.out_y);
          check_field("out_z", want.out_z, got.out_z);
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
          check_field("last", want.last, got.last);
          if (want.face_valid) face_cnt++;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.data.cmd == CMD_WRITE) begin
          if (voxel_live(in_mon.data.pos_x, in_mon.data.pos_y, in_mon.data.pos_z))
            volume[vox_addr(in_mon.data.pos_x, in_mon.data.pos_y, in_mon.data.pos_z)] =
              in_mon.data.value;
        end else begin
          predict_faces(in_mon.data);
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_SIZE_X:      lim_x = cfg_wdata;
          CFG_SIZE_Y:      lim_y = cfg_wdata;
          CFG_SIZE_Z:      lim_z = cfg_wdata;
          CFG_SLICE_LIMIT: lim_slice = cfg_wdata;
          CFG_SHADER_MODE: shade_grey = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    pending = faces_due.size();
  end

endmodule

// File: tb/voxel_exposed_face_extract_top_tb.sv
// ----------------------------------------------------------------------------
// voxel_exposed_face_extract_top_tb
// drives write and query requests into the face extractor under a range of
// volume sizes, slice limits and shading modes, with random gaps on both
// channels; a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module voxel_exposed_face_extract_top_tb import vefe_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 16;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]  cfg_wdata;

  int pending;
  int mismatch_cnt;
  int result_cnt;
  int face_cnt;
  int writes_sent;
  int queries_sent;
  int settings_used;
  bit steady_in;
  bit steady_out;

  vefe_in_if  in_req ();
  vefe_out_if out_resp ();

  voxel_exposed_face_extract_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_resp (out_resp),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  voxel_face_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_req),
    .out_mon     (out_resp),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .pending     (pending),
    .mismatch_cnt(mismatch_cnt),
    .result_cnt  (result_cnt),
    .face_cnt    (face_cnt)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_extent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 1;
    if (r < 24) return MAX_X;
    if (r < 32) return $urandom_range(MAX_X + 1, (1 << CFG_W) - 1);
    if (r < 35) return 0;
    return $urandom_range(2, MAX_X - 1);
  endfunction

  function automatic int pick_slice();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 30) return MAX_Z;
    if (r < 38) return $urandom_range(MAX_Z + 1, (1 << CFG_W) - 1);
    return $urandom_range(1, MAX_Z - 1);
  endfunction

  // corner of a 3x3x3 working box, often against an edge of the live volume
  function automatic int pick_base(int ext);
    int e;
    int r;
    e = (ext > MAX_X) ? MAX_X : ext;
    if (e < 3) e = 3;
    r = $urandom_range(0, 99);
    if (r < 35) return 0;
    if (r < 70) return e - 3;
    return $urandom_range(0, MAX_X - 3);
  endfunction

  task automatic send_req(logic cmd, int x, int y, int z, int val);
    vefe_in_t req;
    int       gap;
    req.cmd   = cmd;
    req.pos_x = POS_W'(x);
    req.pos_y = POS_W'(y);
    req.pos_z = POS_W'(z);
    req.value = VAL_W'(val);
    gap = steady_in ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.data  <= req;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    if (cmd == CMD_WRITE) writes_sent++;
    else queries_sent++;
  endtask

  task automatic put_voxel(int x, int y, int z, int val);
    send_req(CMD_WRITE, x, y, z, val);
  endtask

  task automatic ask_faces(int x, int y, int z);
    send_req(CMD_QUERY, x, y, z, $urandom_range(0, 255));
  endtask

  task automatic drain();
    @(negedge clk);
    in_req.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_regs(int sx, int sy, int sz, int sl, int mode);
    logic [CIDX_W-1:0] idx [6];
    int                val [6];
    idx[0] = CFG_SIZE_X;
    idx[1] = CFG_SIZE_Y;
    idx[2] = CFG_SIZE_Z;
    idx[3] = CFG_SLICE_LIMIT;
    idx[4] = CFG_SHADER_MODE;
    idx[5] = CIDX_W'($urandom_range(int'(CFG_SHADER_MODE) + 1, (1 << CIDX_W) - 1));
    val[0] = sx;
    val[1] = sy;
    val[2] = sz;
    val[3] = sl;
    val[4] = mode;
    val[5] = $urandom;
    for (int k = 0; k < 6; k++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_idx   <= idx[k];
      cfg_wdata <= CFG_W'(val[k]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin : out_pace
    int hold;
    hold = 0;
    out_resp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (steady_out || $urandom_range(0, 1) == 1) begin
        out_resp.ready <= 1'b1;
        hold = $urandom_range(0, 5);
      end else begin
        out_resp.ready <= 1'b0;
        hold = idle_len();
      end
    end
  end

  initial begin
    #25ms;
    $display("voxel_exposed_face_extract_top_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    int   sx;
    int   sy;
    int   sz;
    int   sl;
    int   bx;
    int   by;
    int   bz;
    int   x;
    int   y;
    int   z;
    int   v;
    int   r;
    logic cmd;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    in_req.valid = 1'b0;
    in_req.data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset sizes: lone voxel, partial cover, both colours, far corner
    ask_faces(0, 0, 0);
    put_voxel(0, 0, 0, 1);
    ask_faces(0, 0, 0);
    put_voxel(1, 0, 0, 2);
    put_voxel(0, 1, 0, 255);
    ask_faces(0, 0, 0);
    ask_faces(1, 0, 0);
    put_voxel(31, 31, 31, 128);
    ask_faces(31, 31, 31);
    // fully enclosed voxel
    put_voxel(5, 5, 5, 3);
    put_voxel(4, 5, 5, 1);
    put_voxel(6, 5, 5, 2);
    put_voxel(5, 4, 5, 4);
    put_voxel(5, 6, 5, 8);
    put_voxel(5, 5, 6, 16);
    put_voxel(5, 5, 4, 32);
    ask_faces(5, 5, 5);
    put_voxel(0, 1, 0, 0);
    ask_faces(0, 0, 0);
    drain();

    // one-voxel volume, grey shading, write outside the sizes
    set_regs(1, 1, 1, MAX_Z, 1);
    ask_faces(1, 0, 0);
    ask_faces(0, 0, 0);
    put_voxel(3, 0, 0, 9);
    drain();
    // nothing live under a zero slice limit or a zero size
    set_regs((1 << CFG_W) - 1, (1 << CFG_W) - 1, (1 << CFG_W) - 1, 0, 1);
    ask_faces(31, 31, 31);
    put_voxel(2, 2, 2, 5);
    drain();
    set_regs(0, MAX_Y, MAX_Z, MAX_Z, 0);
    ask_faces(0, 0, 0);
    drain();
    // oversized registers saturate
    set_regs((1 << CFG_W) - 1, (1 << CFG_W) - 1, (1 << CFG_W) - 1, MAX_Z, 1);
    ask_faces(3, 0, 0);
    ask_faces(2, 2, 2);
    ask_faces(31, 31, 31);
    ask_faces(1, 0, 0);
    drain();
    // slice limit just above an odd layer
    set_regs(MAX_X, MAX_Y, MAX_Z, 6, 0);
    ask_faces(5, 5, 5);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        sx = MAX_X;
        sy = MAX_Y;
        sz = MAX_Z;
        sl = MAX_Z;
      end else begin
        sx = pick_extent();
        sy = pick_extent();
        sz = pick_extent();
        sl = pick_slice();
      end
      set_regs(sx, sy, sz, sl, (phase == 0) ? 0 : $urandom_range(0, 1));
      bx = pick_base(sx);
      by = pick_base(sy);
      bz = pick_base((sz < sl) ? sz : sl);
      steady_in  = ($urandom_range(0, 3) == 0);
      steady_out = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 60; i++) begin
        cmd = ($urandom_range(0, 99) < 55) ? CMD_WRITE : CMD_QUERY;
        if ($urandom_range(0, 99) < 78) begin
          x = bx + $urandom_range(0, 2);
          y = by + $urandom_range(0, 2);
          z = bz + $urandom_range(0, 2);
        end else begin
          x = $urandom_range(0, MAX_X - 1);
          y = $urandom_range(0, MAX_Y - 1);
          z = $urandom_range(0, MAX_Z - 1);
        end
        r = $urandom_range(0, 99);
        v = (r < 25) ? 0 : $urandom_range(0, 255);
        send_req(cmd, x, y, z, v);
      end
      // hold the sender back until the block has caught up
      drain();
    end
    steady_in  = 1'b0;
    steady_out = 1'b0;

    $display("covered %0d writes and %0d queries over %0d register settings",
             writes_sent, queries_sent, settings_used);
    $display("checked %0d results, %0d of them faces", result_cnt, face_cnt);
    if (mismatch_cnt == 0) begin
      $display("voxel_exposed_face_extract_top_tb: done, clean");
    end else begin
      $display("voxel_exposed_face_extract_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
src/vefe_pkg.sv
src/vefe_if.sv
src/vefe_store.sv
src/voxel_exposed_face_extract_top.sv
src/vefe_checker.sv
tb/voxel_face_checker.sv
tb/voxel_exposed_face_extract_top_tb.sv
